### hdl/snq_pkg.sv
// Shared types, scale interval tables and pitch-class helpers for the scale note quantiser.
package snq_pkg;

    localparam int PITCH_CLASSES = 12;
    localparam int TYPE_COUNT    = 14;
    localparam int MAX_DISTANCE  = 6;
    localparam int NOTE_MAX      = 127;

    typedef logic [PITCH_CLASSES-1:0] pc_mask_t;
    typedef logic [3:0]               pc_t;
    typedef logic [3:0]               scale_type_t;
    typedef logic [6:0]               note_t;
    typedef logic [3:0]               degree_t;
    typedef logic [3:0]               cfg_data_t;
    typedef logic [0:0]               cfg_addr_t;

    // Register indexes on the configuration port
    localparam cfg_addr_t CFG_SCALE_ROOT = 1'b0;
    localparam cfg_addr_t CFG_SCALE_TYPE = 1'b1;

    // Bit i set when the scale holds the interval of i semitones above the root
    localparam pc_mask_t SCALE_MASKS [TYPE_COUNT] = '{
        12'hAB5,  // major
        12'h5AD,  // natural minor
        12'h9AD,  // harmonic minor
        12'hAAD,  // melodic minor
        12'h6AD,  // dorian
        12'h5AB,  // phrygian
        12'hAD5,  // lydian
        12'h6B5,  // mixolydian
        12'h56B,  // locrian
        12'h295,  // major pentatonic
        12'h4A9,  // minor pentatonic
        12'h4E9,  // blues
        12'h555,  // whole tone
        12'hFFF   // chromatic
    };

    typedef struct packed {
        pc_mask_t intervals;   // relative to the root
        pc_mask_t pitch_mask;  // absolute pitch classes, root applied
        pc_t      root;        // normalised to 0..11
    } scale_cfg_t;

    typedef struct packed {
        note_t   note;
        logic    in_scale;
        degree_t degree;
    } quant_result_t;

    // Note modulo 12 by reciprocal multiply (43/512), exact for 0..127
    function automatic pc_t pitch_class(input note_t note);
        logic [12:0] prod;
        logic [3:0]  quot;
        logic [6:0]  rem;
        prod = 13'(note) * 13'd43;
        quot = prod[12:9];
        rem  = note - 7'(7'(quot) * 7'd12);
        return rem[3:0];
    endfunction

    // (a - b) modulo 12 for a, b in 0..11
    function automatic pc_t pc_sub(input pc_t a, input pc_t b);
        logic [4:0] s;
        s = 5'(a) + 5'(PITCH_CLASSES) - 5'(b);
        if (s >= 5'(PITCH_CLASSES)) begin
            s = s - 5'(PITCH_CLASSES);
        end
        return s[3:0];
    endfunction

    // 1-based position of rel in the interval list, 0 when absent
    function automatic degree_t degree_of(input pc_mask_t intervals, input pc_t rel);
        degree_t cnt;
        cnt = '0;
        for (int i = 0; i < PITCH_CLASSES; i++) begin
            if (intervals[i] && (4'(i) < rel)) begin
                cnt = cnt + 4'd1;
            end
        end
        return intervals[rel] ? cnt + 4'd1 : '0;
    endfunction

endpackage

### hdl/snq_cfg.sv
// Scale configuration registers and derived pitch-class masks.
module snq_cfg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  snq_pkg::cfg_addr_t    cfg_addr,
    input  snq_pkg::cfg_data_t    cfg_wdata,
    output snq_pkg::scale_cfg_t   scale_cfg
);
    import snq_pkg::*;

    pc_t         root_reg;
    scale_type_t type_reg;
    pc_t         root_norm;
    scale_type_t type_norm;
    pc_mask_t    intervals;
    pc_mask_t    pitch_mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
            type_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SCALE_ROOT: root_reg <= cfg_wdata;
                CFG_SCALE_TYPE: type_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Wrap roots 12..15, fall back to major for unlisted types
    always_comb begin
        root_norm = (root_reg >= 4'(PITCH_CLASSES)) ? root_reg - 4'(PITCH_CLASSES) : root_reg;
        type_norm = (type_reg >= 4'(TYPE_COUNT)) ? '0 : type_reg;
        intervals = SCALE_MASKS[type_norm];
        for (int pc = 0; pc < PITCH_CLASSES; pc++) begin
            pitch_mask[pc] = intervals[pc_sub(4'(pc), root_norm)];
        end
    end

    assign scale_cfg = '{intervals: intervals, pitch_mask: pitch_mask, root: root_norm};

endmodule

### hdl/snq_search.sv
// Nearest in-scale note search over distances 1 to 6, upward first.
module snq_search (
    input  snq_pkg::note_t         note,
    input  snq_pkg::scale_cfg_t    scale_cfg,
    output snq_pkg::quant_result_t result
);
    import snq_pkg::*;

    pc_t        pc;
    logic       in_scale;
    logic       up_ok [1:MAX_DISTANCE];
    logic       dn_ok [1:MAX_DISTANCE];
    pc_t        up_pc [1:MAX_DISTANCE];
    pc_t        dn_pc [1:MAX_DISTANCE];
    logic       hit;
    note_t      sel_note;
    pc_t        sel_pc;
    logic [4:0] up_sum;

    always_comb begin
        pc       = pitch_class(note);
        in_scale = scale_cfg.pitch_mask[pc];

        // Candidate checks at each distance are independent
        for (int d = 1; d <= MAX_DISTANCE; d++) begin
            up_sum = 5'(pc) + 5'(d);
            if (up_sum >= 5'(PITCH_CLASSES)) begin
                up_sum = up_sum - 5'(PITCH_CLASSES);
            end
            up_pc[d] = up_sum[3:0];
            dn_pc[d] = pc_sub(pc, 4'(d));
            up_ok[d] = (8'(note) + 8'(d) <= 8'(NOTE_MAX)) && scale_cfg.pitch_mask[up_pc[d]];
            dn_ok[d] = (note >= 7'(d)) && scale_cfg.pitch_mask[dn_pc[d]];
        end

        // Farthest first so the nearest candidate, upward on ties, wins
        hit      = 1'b0;
        sel_note = note;
        sel_pc   = pc;
        for (int d = MAX_DISTANCE; d >= 1; d--) begin
            if (dn_ok[d]) begin
                hit      = 1'b1;
                sel_note = note - 7'(d);
                sel_pc   = dn_pc[d];
            end
            if (up_ok[d]) begin
                hit      = 1'b1;
                sel_note = note + 7'(d);
                sel_pc   = up_pc[d];
            end
        end
        if (in_scale) begin
            hit      = 1'b1;
            sel_note = note;
            sel_pc   = pc;
        end

        result.note     = sel_note;
        result.in_scale = in_scale;
        result.degree   = hit ? degree_of(scale_cfg.intervals, pc_sub(sel_pc, scale_cfg.root))
                              : '0;
    end

endmodule

### hdl/scale_note_quantizer_top.sv
// Top level of the scale note quantiser: input register, search logic, result register.
//
// Snaps each incoming MIDI note to the nearest note of the configured scale. The scale
// is a root pitch class (register 0, values 12..15 wrap modulo 12) and one of fourteen
// scale types (register 1: major, natural minor, harmonic minor, melodic minor, dorian,
// phrygian, lydian, mixolydian, locrian, major pentatonic, minor pentatonic, blues,
// whole tone, chromatic; 14 and 15 select major). A note already in the scale passes
// with was_in_scale set; otherwise the nearest scale note within six semitones is
// returned, the higher one on a tie, never leaving 0..127. scale_degree is the 1-based
// position of the output note in the scale, 0 only if nothing was found. The block takes
// one beat every clock cycle while the result register is empty or m_tready drains it;
// each beat passes through the input register, then the search logic as a single pass
// of logic, then the result register. The input register can take a new beat while a
// finished result still waits on m_tready, but only if it holds no beat itself.
// Write configuration only while the block holds no beats in flight.
module scale_note_quantizer_top (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [6:0] note_in, [7] zero

    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,    // [6:0] note_out, [10:7] scale_degree, [15:11] zero
    output logic [0:0]         m_tuser,    // [0] was_in_scale

    input  logic               cfg_we,
    input  snq_pkg::cfg_addr_t cfg_addr,
    input  snq_pkg::cfg_data_t cfg_wdata
);
    import snq_pkg::*;

    logic          in_valid_reg;
    note_t         in_note_reg;
    logic          out_valid_reg;
    quant_result_t out_result_reg;
    logic          advance;
    scale_cfg_t    scale_cfg;
    quant_result_t search_result;

    snq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .scale_cfg (scale_cfg)
    );

    snq_search u_search (
        .note      (in_note_reg),
        .scale_cfg (scale_cfg),
        .result    (search_result)
    );

    // Move the input stage on whenever the result register is empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Input register: capture a beat, drop the valid once it has moved on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_note_reg <= s_tdata[6:0];
        end
    end

    // Result register: hold until taken, then advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_result_reg <= search_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_result_reg.degree, out_result_reg.note};
    assign m_tuser  = out_result_reg.in_scale;

    // A note found in the scale always carries a degree
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_result_reg.in_scale) |-> (out_result_reg.degree != '0))
    else $error("in-scale result without a degree");

    // A beat in the input stage reaches the result register when the stage advances
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance) |=> out_valid_reg)
    else $error("beat lost between input and result registers");

    // A waiting result is never dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_result_reg)))
    else $error("pending result dropped or altered");

endmodule

### dv/scale_note_quantizer_top_test.sv
// Self-checking testbench for the scale note quantiser: directed edge notes, then random beats.
module scale_note_quantizer_top_test;
    import snq_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 11;
    // Slack after the pipeline has drained, before touching the registers or ending the run
    localparam int SETTLE_CYCLES   = 4;
    // Cycles without any accepted beat on either side before the run is declared hung
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_PHASES   = 16;
    localparam int NOTES_PER_PHASE = 44;
    localparam int SWEEP_NOTES     = 6;
    localparam int IDLE_PERCENT    = 37;

    // Scale type register codes; the last two are unlisted and fall back to major
    typedef enum logic [3:0] {
        SCALE_MAJOR,
        SCALE_NATURAL_MINOR,
        SCALE_HARMONIC_MINOR,
        SCALE_MELODIC_MINOR,
        SCALE_DORIAN,
        SCALE_PHRYGIAN,
        SCALE_LYDIAN,
        SCALE_MIXOLYDIAN,
        SCALE_LOCRIAN,
        SCALE_MAJOR_PENTATONIC,
        SCALE_MINOR_PENTATONIC,
        SCALE_BLUES,
        SCALE_WHOLE_TONE,
        SCALE_CHROMATIC,
        SCALE_SPARE_A,
        SCALE_SPARE_B
    } scale_kind_e;

    typedef struct packed {
        note_t   note;
        logic    in_scale;
        degree_t degree;
    } snapped_note_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;    // [6:0] note_in, [7] zero
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [15:0]        m_tdata;    // [6:0] note_out, [10:7] scale_degree, [15:11] zero
    logic [0:0]         m_tuser;    // [0] was_in_scale
    logic               cfg_we;
    cfg_addr_t          cfg_addr;
    cfg_data_t          cfg_wdata;

    // Shadow copies of the two registers, raw 4-bit values as written
    cfg_data_t          root_reg = '0;
    cfg_data_t          kind_reg = '0;

    snapped_note_t      pending_notes [$];
    snapped_note_t      want;
    snapped_note_t      got;
    int unsigned        mismatches = 0;
    // Set to run both sides flat out with no idle cycles
    bit                 no_gaps = 1'b0;

    scale_note_quantizer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #(HALF_PERIOD);
        aclk = 1'b1;
        #(HALF_PERIOD);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Interval set of each scale type, bit i = i semitones above the root
    function automatic pc_mask_t intervals_of(cfg_data_t kind);
        case (scale_kind_e'(kind))
            SCALE_NATURAL_MINOR:    return 12'b0101_1010_1101;
            SCALE_HARMONIC_MINOR:   return 12'b1001_1010_1101;
            SCALE_MELODIC_MINOR:    return 12'b1010_1010_1101;
            SCALE_DORIAN:           return 12'b0110_1010_1101;
            SCALE_PHRYGIAN:         return 12'b0101_1010_1011;
            SCALE_LYDIAN:           return 12'b1010_1101_0101;
            SCALE_MIXOLYDIAN:       return 12'b0110_1011_0101;
            SCALE_LOCRIAN:          return 12'b0101_0110_1011;
            SCALE_MAJOR_PENTATONIC: return 12'b0010_1001_0101;
            SCALE_MINOR_PENTATONIC: return 12'b0100_1010_1001;
            SCALE_BLUES:            return 12'b0100_1110_1001;
            SCALE_WHOLE_TONE:       return 12'b0101_0101_0101;
            SCALE_CHROMATIC:        return 12'b1111_1111_1111;
            // major, and the unlisted codes that fall back to it
            default:                return 12'b1010_1011_0101;
        endcase
    endfunction

    // 1-based degree of a candidate note in the current scale; 0 when the note is
    // outside the MIDI range or not in the scale
    function automatic degree_t scale_position(int n);
        pc_mask_t mask;
        int       rel;
        degree_t  pos;
        mask = intervals_of(kind_reg);
        if (n < 0 || n > NOTE_MAX) begin
            return '0;
        end
        rel = (n % PITCH_CLASSES + PITCH_CLASSES - int'(root_reg) % PITCH_CLASSES)
              % PITCH_CLASSES;
        if (!mask[rel]) begin
            return '0;
        end
        pos = 4'd1;
        for (int i = 0; i < rel; i++) begin
            if (mask[i]) begin
                pos = pos + 4'd1;
            end
        end
        return pos;
    endfunction

    function automatic snapped_note_t snap_note(note_t n);
        snapped_note_t r;
        degree_t       pos;
        bit            found;
        r.note     = n;
        r.in_scale = 1'b0;
        r.degree   = '0;
        found      = 1'b0;
        pos        = scale_position(int'(n));
        if (pos != '0) begin
            r.in_scale = 1'b1;
            r.degree   = pos;
            return r;
        end
        // Widen the search one semitone at a time, upward before downward
        for (int d = 1; d <= MAX_DISTANCE && !found; d++) begin
            pos = scale_position(int'(n) + d);
            if (pos != '0) begin
                r.note   = note_t'(int'(n) + d);
                r.degree = pos;
                found    = 1'b1;
            end else begin
                pos = scale_position(int'(n) - d);
                if (pos != '0) begin
                    r.note   = note_t'(int'(n) - d);
                    r.degree = pos;
                    found    = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    // Stall the result side at random; hold ready high through gap-free stretches
    always @(posedge aclk) begin
        m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Offer one note beat and hold it until accepted. Valid stays high afterwards so
    // back-to-back beats never see it dropped and raised in the same step.
    task automatic send_note(note_t n);
        while (take_gap()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, n};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_notes.insert(pending_notes.size(), snap_note(n));
    endtask

    // Drop valid and wait for every outstanding result to come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_notes.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Registers change only with the pipeline empty
    task automatic write_scale_reg(cfg_addr_t idx, cfg_data_t value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_SCALE_ROOT) begin
            root_reg = value;
        end else begin
            kind_reg = value;
        end
    endtask

    task automatic set_scale(cfg_data_t root, scale_kind_e kind);
        write_scale_reg(CFG_SCALE_ROOT, root);
        write_scale_reg(CFG_SCALE_TYPE, cfg_data_t'(kind));
    endtask

    // Mostly uniform notes, with the range ends pulled in now and then
    function automatic note_t random_note();
        case ($urandom_range(0, 15))
            0:       return note_t'(0);
            1:       return note_t'(NOTE_MAX);
            2:       return note_t'($urandom_range(0, MAX_DISTANCE));
            3:       return note_t'($urandom_range(NOTE_MAX - MAX_DISTANCE, NOTE_MAX));
            default: return note_t'($urandom_range(0, NOTE_MAX));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Compare each accepted result beat against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.note     = m_tdata[6:0];
            got.degree   = m_tdata[10:7];
            got.in_scale = m_tuser[0];
            if (pending_notes.size() == 0) begin
                report_mismatch($sformatf("unexpected result note_out=%0d", got.note));
            end else begin
                want = pending_notes.pop_front();
                if (got.note !== want.note) begin
                    report_mismatch($sformatf("note_out %0d, want %0d",
                                              got.note, want.note));
                end
                if (got.in_scale !== want.in_scale) begin
                    report_mismatch($sformatf("was_in_scale %0d, want %0d (note_out %0d)",
                                              got.in_scale, want.in_scale, want.note));
                end
                if (got.degree !== want.degree) begin
                    report_mismatch($sformatf("scale_degree %0d, want %0d (note_out %0d)",
                                              got.degree, want.degree, want.note));
                end
            end
        end
    end

    // Abort if neither side moves a beat for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("scale_note_quantizer_top_test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // C major straight out of reset: range ends, an in-scale note, and two
    // out-of-scale notes where upward wins the tie
    task automatic test_reset_scale();
        send_note(note_t'(0));
        send_note(note_t'(NOTE_MAX));
        send_note(note_t'(60));
        send_note(note_t'(61));
        send_note(note_t'(66));
    endtask

    // Candidates that fall below 0 or above 127 must be skipped
    task automatic test_range_edges();
        set_scale(4'd2, SCALE_MAJOR_PENTATONIC);
        send_note(note_t'(0));
        send_note(note_t'(1));
        send_note(note_t'(NOTE_MAX));
        // root 12 wraps to C
        set_scale(4'd12, SCALE_WHOLE_TONE);
        send_note(note_t'(1));
        send_note(note_t'(NOTE_MAX));
        set_scale(4'd0, SCALE_CHROMATIC);
        send_note(note_t'(0));
        send_note(note_t'(NOTE_MAX));
    endtask

    // Unlisted type codes select major; root 15 wraps to 3
    task automatic test_unlisted_codes();
        set_scale(4'd15, SCALE_SPARE_B);
        send_note(note_t'(0));
        send_note(note_t'(64));
        send_note(note_t'(NOTE_MAX));
        set_scale(4'd11, SCALE_SPARE_A);
        send_note(note_t'(0));
        send_note(note_t'(NOTE_MAX));
    endtask

    // Every listed scale type once, each on a random root
    task automatic test_scale_sweep();
        for (int k = 0; k <= int'(SCALE_CHROMATIC); k++) begin
            set_scale(cfg_data_t'($urandom_range(0, PITCH_CLASSES - 1)), scale_kind_e'(k));
            repeat (SWEEP_NOTES) send_note(random_note());
        end
    endtask

    // Random scale per phase, random notes within; one phase pair runs gap-free and
    // one phase stops mid-way until the pipeline has emptied
    task automatic test_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_scale(cfg_data_t'($urandom_range(0, 15)), scale_kind_e'($urandom_range(0, 15)));
            no_gaps = (p == 6 || p == 7);
            for (int i = 0; i < NOTES_PER_PHASE; i++) begin
                if (p == 3 && i == NOTES_PER_PHASE / 2) begin
                    drain_results();
                end
                send_note(random_note());
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_SCALE_ROOT;
        cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn   <= 1'b1;

        test_reset_scale();
        test_range_edges();
        test_unlisted_codes();
        test_scale_sweep();
        test_random_phases();

        // Let the last results out, then allow stray beats a chance to show up
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_notes.size() == 0) begin
            $display("scale_note_quantizer_top_test passed");
        end else begin
            $display("scale_note_quantizer_top_test failed");
        end
        $finish;
    end

endmodule

### scale_note_quantizer_top.f
hdl/snq_pkg.sv
hdl/snq_cfg.sv
hdl/snq_search.sv
hdl/scale_note_quantizer_top.sv
dv/scale_note_quantizer_top_test.sv
